// ===== hdl/avr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avr_pkg
// Shared types, constants and arithmetic helpers of the axis-angle rotator.
// ----------------------------------------------------------------------------
package avr_pkg;

  localparam int COMPONENT_WIDTH_DEF  = 32;
  localparam int ANGLE_ITERATIONS_DEF = 24;

  localparam int FIELD_W     = 32;
  localparam int XW          = 50;
  localparam int ZW          = 62;
  localparam int ROOT_STEPS  = 32;
  localparam int DIV_STEPS   = 31;
  localparam int RD_W        = 37;
  localparam int PR_W        = 66;
  localparam int GUARD       = 16;
  localparam int NORM_STAGES = 69;
  localparam int MUL_STAGES  = 8;

  localparam longint PI_Q56   = 64'h0324_3F6A_8885_A309;
  localparam longint GAIN_Q30 = 64'h0000_0000_26DD_3B6A;
  localparam longint ONE_Q30  = 64'h0000_0000_4000_0000;

  typedef logic signed [FIELD_W-1:0] comp_t;
  typedef logic signed [RD_W-1:0]    rd_t;
  typedef logic signed [PR_W-1:0]    prod_t;

  typedef struct packed {
    comp_t [2:0] p;
    logic  [2:0] a_neg;
    logic        zero;
  } side_t;

  function automatic rd_t round_q30(input prod_t p);
    logic [PR_W-1:0] mag;
    logic [PR_W-1:0] rnd;
    mag = p[PR_W-1] ? PR_W'(-p) : PR_W'(p);
    rnd = (mag + (PR_W'(1) << 29)) >> 30;
    return p[PR_W-1] ? -rd_t'(rnd[RD_W-1:0]) : rd_t'(rnd[RD_W-1:0]);
  endfunction

  function automatic longint atan_pow2(input int n);
    longint          sum;
    int              e;
    longint unsigned Den;
    longint unsigned term;
    sum = 0;
    if (n == 0) begin
      return PI_Q56 >>> 2;
    end
    for (int m = 0; m < 64; m++) begin
      e = 56 - n * (2 * m + 1);
      if (e >= 0) begin
        Den  = longint'(2 * m + 1);
        term = (64'd1 << e) / Den;
        if ((m & 1) != 0) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
    end
    return sum;
  endfunction

endpackage

// ===== hdl/avr_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avr_if
// Valid/ready channels for input and result transactions.
// ----------------------------------------------------------------------------
interface avr_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vec_x;
  logic signed [31:0] vec_y;
  logic signed [31:0] vec_z;
  logic signed [31:0] axis_x;
  logic signed [31:0] axis_y;
  logic signed [31:0] axis_z;
  logic signed [31:0] angle;

  modport source (output valid, vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle,
                  input ready);
  modport sink (input valid, vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle,
                output ready);
endinterface

interface avr_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] rot_x;
  logic signed [31:0] rot_y;
  logic signed [31:0] rot_z;
  logic               zero_axis;
  logic               saturated;

  modport source (output valid, rot_x, rot_y, rot_z, zero_axis, saturated, input ready);
  modport sink (input valid, rot_x, rot_y, rot_z, zero_axis, saturated, output ready);
endinterface

// ===== hdl/avr_root_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avr_root_cell
// One digit of the integer square root, two radicand bits per cell.
// ----------------------------------------------------------------------------
module avr_root_cell import avr_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] rem_i,
  input  logic [63:0] root_i,
  output logic [63:0] rem_o,
  output logic [63:0] root_o
);

  localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

  logic [64:0] sum_w;
  logic        take;
  logic [63:0] rem_d;
  logic [63:0] root_d;
  logic [63:0] rem_q;
  logic [63:0] root_q;

  always_comb begin
    sum_w  = {1'b0, root_i} + {1'b0, BIT};
    take   = {1'b0, rem_i} >= sum_w;
    rem_d  = take ? (rem_i - sum_w[63:0]) : rem_i;
    root_d = take ? ((root_i >> 1) + BIT) : (root_i >> 1);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign rem_o  = rem_q;
  assign root_o = root_q;

endmodule

// ===== hdl/avr_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avr_div_cell
// One restoring quotient bit for the three axis lanes against a shared divisor.
// ----------------------------------------------------------------------------
module avr_div_cell import avr_pkg::*; (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [31:0]                 dvs_i,
  input  logic [2:0][31:0]            rem_i,
  input  logic [2:0][DIV_STEPS-1:0]   word_i,
  output logic [31:0]                 dvs_o,
  output logic [2:0][31:0]            rem_o,
  output logic [2:0][DIV_STEPS-1:0]   word_o
);

  logic [2:0][32:0]          trial;
  logic [2:0]                ge;
  logic [2:0][31:0]          rem_d;
  logic [2:0][DIV_STEPS-1:0] word_d;
  logic [31:0]               dvs_q;
  logic [2:0][31:0]          rem_q;
  logic [2:0][DIV_STEPS-1:0] word_q;

  always_comb begin
    for (int n = 0; n < 3; n++) begin
      trial[n]  = {rem_i[n], word_i[n][DIV_STEPS-1]};
      ge[n]     = trial[n] >= {1'b0, dvs_i};
      rem_d[n]  = ge[n] ? 32'(trial[n] - {1'b0, dvs_i}) : trial[n][31:0];
      word_d[n] = {word_i[n][DIV_STEPS-2:0], ge[n]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dvs_q  <= dvs_i;
      rem_q  <= rem_d;
      word_q <= word_d;
    end
  end

  assign dvs_o  = dvs_q;
  assign rem_o  = rem_q;
  assign word_o = word_q;

endmodule

// ===== hdl/avr_cordic_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avr_cordic_cell
// One rotation-mode CORDIC micro-rotation by atan(2^-STEP).
// ----------------------------------------------------------------------------
module avr_cordic_cell import avr_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  input  logic                 neg_i,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output logic signed [ZW-1:0] z_o,
  output logic                 neg_o
);

  localparam logic signed [ZW-1:0] ATAN = ZW'(atan_pow2(STEP));

  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  logic signed [XW-1:0] x_d;
  logic signed [XW-1:0] y_d;
  logic signed [ZW-1:0] z_d;
  logic signed [XW-1:0] x_q;
  logic signed [XW-1:0] y_q;
  logic signed [ZW-1:0] z_q;
  logic                 neg_q;

  always_comb begin
    dx = y_i >>> STEP;
    dy = x_i >>> STEP;
    if (!z_i[ZW-1]) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - ATAN;
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + ATAN;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q   <= x_d;
      y_q   <= y_d;
      z_q   <= z_d;
      neg_q <= neg_i;
    end
  end

  assign x_o   = x_q;
  assign y_o   = y_q;
  assign z_o   = z_q;
  assign neg_o = neg_q;

endmodule

// ===== hdl/axis_angle_vector_rotation_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axis_angle_vector_rotation_top
// Rotates a Q16.16 vector about an arbitrary axis by a Q4.28 angle (Rodrigues).
// ----------------------------------------------------------------------------
// Fully pipelined: one transaction enters per cycle unless the sink holds the
// result register, and its result passes through the axis normalization path:
// magnitude prep (absolute values and maximum, normalizing shift, squares and
// their sum), 32 square-root cells, one divide prep, 31 divide cells and one
// sign stage for the three unit-axis components, then the multiply, round and
// sum stages. The CORDIC cell chain for sine and cosine runs beside it. When
// the result register is held by the sink the whole pipeline holds in place.
// A zero-length axis passes the vector through with zero_axis set.
module axis_angle_vector_rotation_top import avr_pkg::*; #(
  parameter int COMPONENT_WIDTH  = COMPONENT_WIDTH_DEF,
  parameter int ANGLE_ITERATIONS = ANGLE_ITERATIONS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  avr_in_if.sink     in_i,
  avr_out_if.source  out_o
);

  localparam int EFF_W    = (COMPONENT_WIDTH > 32) ? 32 :
                            ((COMPONENT_WIDTH < 2) ? 2 : COMPONENT_WIDTH);
  localparam int TOTAL    = NORM_STAGES + MUL_STAGES;
  localparam int SIDE_LEN = TOTAL - 1;
  localparam int ANG_DLY  = NORM_STAGES - 3 - ANGLE_ITERATIONS;
  localparam int MA_DLY   = ROOT_STEPS + 2;

  localparam logic signed [ZW-1:0] PI_Z   = ZW'(PI_Q56);
  localparam logic signed [ZW-1:0] TWO_PI = ZW'(PI_Q56 * 2);
  localparam logic signed [ZW-1:0] HPI_Z  = ZW'(PI_Q56 >>> 1);
  localparam logic signed [XW-1:0] X_INIT = XW'(GAIN_Q30 <<< GUARD);
  localparam logic signed [XW-1:0] HALF_X = XW'(64'd1 << (GUARD - 1));
  localparam logic signed [XW-1:0] ONE_X  = XW'(ONE_Q30);
  localparam logic signed [38:0]   SAT_HI = 39'((64'sd1 <<< (EFF_W - 1)) - 1);
  localparam logic signed [38:0]   SAT_LO = -SAT_HI - 39'sd1;

  logic en;
  logic [TOTAL-1:0] valid_q;

  assign en          = !valid_q[TOTAL-1] || out_o.ready;
  assign in_i.ready  = en;
  assign out_o.valid = valid_q[TOTAL-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[TOTAL-2:0], in_i.valid};
    end
  end

  // input decode
  comp_t [2:0] p_in;
  comp_t [2:0] a_in;
  side_t       side_in;

  always_comb begin
    p_in[0] = 32'($signed(in_i.vec_x[EFF_W-1:0]));
    p_in[1] = 32'($signed(in_i.vec_y[EFF_W-1:0]));
    p_in[2] = 32'($signed(in_i.vec_z[EFF_W-1:0]));
    a_in[0] = 32'($signed(in_i.axis_x[EFF_W-1:0]));
    a_in[1] = 32'($signed(in_i.axis_y[EFF_W-1:0]));
    a_in[2] = 32'($signed(in_i.axis_z[EFF_W-1:0]));
    side_in.p     = p_in;
    side_in.a_neg = {a_in[2][31], a_in[1][31], a_in[0][31]};
    side_in.zero  = (a_in[0] == '0) && (a_in[1] == '0) && (a_in[2] == '0);
  end

  side_t side_q [SIDE_LEN];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_in;
      for (int i = 1; i < SIDE_LEN; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // axis magnitude prep
  logic [2:0][31:0] ma_n1_q;
  logic [31:0]      mx_n1_q;
  logic [2:0][31:0] ma_abs;
  logic [31:0]      mx_d;

  always_comb begin
    for (int n = 0; n < 3; n++) begin
      ma_abs[n] = a_in[n][31] ? 32'(-a_in[n]) : 32'(a_in[n]);
    end
    mx_d = ma_abs[0];
    if (ma_abs[1] > mx_d) begin
      mx_d = ma_abs[1];
    end
    if (ma_abs[2] > mx_d) begin
      mx_d = ma_abs[2];
    end
  end

  logic [4:0]       sh;
  logic [2:0][31:0] ma_n2_q;
  logic [2:0][63:0] sqr_q;
  logic [63:0]      sum_q;

  always_comb begin
    sh = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (mx_n1_q[i]) begin
        sh = (i >= 30) ? 5'd0 : 5'(30 - i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ma_n1_q <= ma_abs;
      mx_n1_q <= mx_d;
      for (int n = 0; n < 3; n++) begin
        ma_n2_q[n] <= ma_n1_q[n] << sh;
        sqr_q[n]   <= 64'(ma_n2_q[n]) * 64'(ma_n2_q[n]);
      end
      sum_q <= sqr_q[0] + sqr_q[1] + sqr_q[2];
    end
  end

  logic [2:0][31:0] ma_dly_q [MA_DLY];

  always_ff @(posedge clk_i) begin
    if (en) begin
      ma_dly_q[0] <= ma_n2_q;
      for (int i = 1; i < MA_DLY; i++) begin
        ma_dly_q[i] <= ma_dly_q[i-1];
      end
    end
  end

  // square root chain
  logic [63:0] rem_s  [ROOT_STEPS+1];
  logic [63:0] root_s [ROOT_STEPS+1];

  assign rem_s[0]  = sum_q;
  assign root_s[0] = '0;

  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
    avr_root_cell #(.STEP(k)) u_root (
      .clk_i  (clk_i),
      .en_i   (en),
      .rem_i  (rem_s[k]),
      .root_i (root_s[k]),
      .rem_o  (rem_s[k+1]),
      .root_o (root_s[k+1])
    );
  end

  // divide chain
  logic [31:0]               dvs_c  [DIV_STEPS+1];
  logic [2:0][31:0]          rem_c  [DIV_STEPS+1];
  logic [2:0][DIV_STEPS-1:0] word_c [DIV_STEPS+1];
  logic [31:0]               r_w;
  logic [2:0][61:0]          num_w;
  logic [31:0]               dvs0_q;
  logic [2:0][31:0]          rem0_q;
  logic [2:0][DIV_STEPS-1:0] word0_q;

  always_comb begin
    r_w = root_s[ROOT_STEPS][31:0];
    for (int n = 0; n < 3; n++) begin
      num_w[n] = (62'(ma_dly_q[MA_DLY-1][n]) << 30) + 62'(r_w >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dvs0_q <= r_w;
      for (int n = 0; n < 3; n++) begin
        rem0_q[n]  <= 32'(num_w[n] >> DIV_STEPS);
        word0_q[n] <= num_w[n][DIV_STEPS-1:0];
      end
    end
  end

  assign dvs_c[0]  = dvs0_q;
  assign rem_c[0]  = rem0_q;
  assign word_c[0] = word0_q;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    avr_div_cell u_div (
      .clk_i  (clk_i),
      .en_i   (en),
      .dvs_i  (dvs_c[k]),
      .rem_i  (rem_c[k]),
      .word_i (word_c[k]),
      .dvs_o  (dvs_c[k+1]),
      .rem_o  (rem_c[k+1]),
      .word_o (word_c[k+1])
    );
  end

  comp_t [2:0] u_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int n = 0; n < 3; n++) begin
        u_q[n] <= side_q[NORM_STAGES-2].a_neg[n] ? -comp_t'(word_c[DIV_STEPS][n])
                                                 : comp_t'(word_c[DIV_STEPS][n]);
      end
    end
  end

  // angle path
  logic signed [31:0]   ang_q [ANG_DLY];
  logic signed [ZW-1:0] t_w;
  logic signed [ZW-1:0] t_wrap_q;
  logic signed [ZW-1:0] t_quad_q;
  logic                 neg_quad_q;

  assign t_w = ZW'(ang_q[ANG_DLY-1]) <<< 28;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ang_q[0] <= in_i.angle;
      for (int i = 1; i < ANG_DLY; i++) begin
        ang_q[i] <= ang_q[i-1];
      end
      if (t_w > PI_Z) begin
        t_wrap_q <= t_w - TWO_PI;
      end else if (t_w <= -PI_Z) begin
        t_wrap_q <= t_w + TWO_PI;
      end else begin
        t_wrap_q <= t_w;
      end
      if (t_wrap_q > HPI_Z) begin
        t_quad_q   <= t_wrap_q - PI_Z;
        neg_quad_q <= 1'b1;
      end else if (t_wrap_q < -HPI_Z) begin
        t_quad_q   <= t_wrap_q + PI_Z;
        neg_quad_q <= 1'b1;
      end else begin
        t_quad_q   <= t_wrap_q;
        neg_quad_q <= 1'b0;
      end
    end
  end

  logic signed [XW-1:0] cx [ANGLE_ITERATIONS+1];
  logic signed [XW-1:0] cy [ANGLE_ITERATIONS+1];
  logic signed [ZW-1:0] cz [ANGLE_ITERATIONS+1];
  logic                 cn [ANGLE_ITERATIONS+1];

  assign cx[0] = X_INIT;
  assign cy[0] = '0;
  assign cz[0] = t_quad_q;
  assign cn[0] = neg_quad_q;

  for (genvar k = 0; k < ANGLE_ITERATIONS; k++) begin : g_cordic
    avr_cordic_cell #(.STEP(k)) u_cordic (
      .clk_i (clk_i),
      .en_i  (en),
      .x_i   (cx[k]),
      .y_i   (cy[k]),
      .z_i   (cz[k]),
      .neg_i (cn[k]),
      .x_o   (cx[k+1]),
      .y_o   (cy[k+1]),
      .z_o   (cz[k+1]),
      .neg_o (cn[k+1])
    );
  end

  logic signed [XW-1:0] co_r;
  logic signed [XW-1:0] si_r;
  logic signed [XW-1:0] co_c;
  logic signed [XW-1:0] si_c;
  comp_t                co_q;
  comp_t                si_q;

  always_comb begin
    co_r = (cx[ANGLE_ITERATIONS] + HALF_X) >>> GUARD;
    si_r = (cy[ANGLE_ITERATIONS] + HALF_X) >>> GUARD;
    co_c = (co_r > ONE_X) ? ONE_X : ((co_r < -ONE_X) ? -ONE_X : co_r);
    si_c = (si_r > ONE_X) ? ONE_X : ((si_r < -ONE_X) ? -ONE_X : si_r);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      co_q <= cn[ANGLE_ITERATIONS] ? -comp_t'(co_c) : comp_t'(co_c);
      si_q <= cn[ANGLE_ITERATIONS] ? -comp_t'(si_c) : comp_t'(si_c);
    end
  end

  // Rodrigues terms
  prod_t [2:0]      dot_m1_q;
  prod_t [2:0][1:0] cr_m1_q;
  prod_t [2:0]      pc_m1_q;
  comp_t [2:0]      u_m1_q;
  comp_t            co_m1_q;
  comp_t            si_m1_q;

  rd_t   [2:0]      dot_m2_q;
  rd_t   [2:0][1:0] cr_m2_q;
  rd_t   [2:0]      pc_m2_q;
  comp_t [2:0]      u_m2_q;
  comp_t            co_m2_q;
  comp_t            si_m2_q;

  rd_t                ip_m3_q;
  rd_t   [2:0]        kxp_m3_q;
  logic signed [32:0] omc_m3_q;
  rd_t   [2:0]        pc_m3_q;
  comp_t [2:0]        u_m3_q;
  comp_t              si_m3_q;

  prod_t              q_m4_q;
  prod_t [2:0]        ks_m4_q;
  rd_t   [2:0]        pc_m4_q;
  comp_t [2:0]        u_m4_q;

  rd_t                q_m5_q;
  rd_t   [2:0]        ks_m5_q;
  rd_t   [2:0]        pc_m5_q;
  comp_t [2:0]        u_m5_q;

  prod_t [2:0]        uq_m6_q;
  rd_t   [2:0]        ks_m6_q;
  rd_t   [2:0]        pc_m6_q;

  rd_t   [2:0]        uq_m7_q;
  rd_t   [2:0]        ks_m7_q;
  rd_t   [2:0]        pc_m7_q;

  side_t side_end;

  assign side_end = side_q[NORM_STAGES-1];

  for (genvar g = 0; g < 3; g++) begin : g_lane
    localparam int J = (g + 1) % 3;
    localparam int K = (g + 2) % 3;

    always_ff @(posedge clk_i) begin
      if (en) begin
        dot_m1_q[g]   <= PR_W'(u_q[g] * side_end.p[g]);
        cr_m1_q[g][0] <= PR_W'(u_q[J] * side_end.p[K]);
        cr_m1_q[g][1] <= PR_W'(u_q[K] * side_end.p[J]);
        pc_m1_q[g]    <= PR_W'(side_end.p[g] * co_q);

        dot_m2_q[g]   <= round_q30(dot_m1_q[g]);
        cr_m2_q[g][0] <= round_q30(cr_m1_q[g][0]);
        cr_m2_q[g][1] <= round_q30(cr_m1_q[g][1]);
        pc_m2_q[g]    <= round_q30(pc_m1_q[g]);

        kxp_m3_q[g]   <= cr_m2_q[g][0] - cr_m2_q[g][1];
        pc_m3_q[g]    <= pc_m2_q[g];

        ks_m4_q[g]    <= PR_W'(kxp_m3_q[g] * si_m3_q);
        pc_m4_q[g]    <= pc_m3_q[g];

        ks_m5_q[g]    <= round_q30(ks_m4_q[g]);
        pc_m5_q[g]    <= pc_m4_q[g];

        uq_m6_q[g]    <= PR_W'(u_m5_q[g] * q_m5_q);
        ks_m6_q[g]    <= ks_m5_q[g];
        pc_m6_q[g]    <= pc_m5_q[g];

        uq_m7_q[g]    <= round_q30(uq_m6_q[g]);
        ks_m7_q[g]    <= ks_m6_q[g];
        pc_m7_q[g]    <= pc_m6_q[g];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      u_m1_q   <= u_q;
      co_m1_q  <= co_q;
      si_m1_q  <= si_q;
      u_m2_q   <= u_m1_q;
      co_m2_q  <= co_m1_q;
      si_m2_q  <= si_m1_q;
      ip_m3_q  <= dot_m2_q[0] + dot_m2_q[1] + dot_m2_q[2];
      omc_m3_q <= 33'(ONE_Q30) - 33'(co_m2_q);
      u_m3_q   <= u_m2_q;
      si_m3_q  <= si_m2_q;
      q_m4_q   <= PR_W'(ip_m3_q * omc_m3_q);
      u_m4_q   <= u_m3_q;
      q_m5_q   <= round_q30(q_m4_q);
      u_m5_q   <= u_m4_q;
    end
  end

  // sum, clamp and result register
  logic signed [38:0] sum_w [3];
  logic [2:0]         hi_w;
  logic [2:0]         lo_w;
  comp_t [2:0]        rot_d;
  logic               sat_d;
  comp_t [2:0]        rot_q;
  logic               zero_q;
  logic               sat_q;

  always_comb begin
    for (int n = 0; n < 3; n++) begin
      sum_w[n] = 39'(pc_m7_q[n]) + 39'(ks_m7_q[n]) + 39'(uq_m7_q[n]);
      hi_w[n]  = sum_w[n] > SAT_HI;
      lo_w[n]  = sum_w[n] < SAT_LO;
      if (side_q[SIDE_LEN-1].zero) begin
        rot_d[n] = side_q[SIDE_LEN-1].p[n];
      end else if (hi_w[n]) begin
        rot_d[n] = comp_t'(SAT_HI);
      end else if (lo_w[n]) begin
        rot_d[n] = comp_t'(SAT_LO);
      end else begin
        rot_d[n] = comp_t'(sum_w[n]);
      end
    end
    sat_d = !side_q[SIDE_LEN-1].zero && ((hi_w | lo_w) != 3'b000);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rot_q  <= rot_d;
      zero_q <= side_q[SIDE_LEN-1].zero;
      sat_q  <= sat_d;
    end
  end

  assign out_o.rot_x     = rot_q[0];
  assign out_o.rot_y     = rot_q[1];
  assign out_o.rot_z     = rot_q[2];
  assign out_o.zero_axis = zero_q;
  assign out_o.saturated = sat_q;

endmodule
